FILE: design/pgs_pkg.sv
// Shared types, constants and helpers of the polar Gaussian sampler.
package pgs_pkg;

    localparam int UNIFORM_BITS  = 32;
    localparam int OUT_FRAC_BITS = 16;

    localparam int IN_W      = 32;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MEAN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STD  = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] STD_RESET = CFG_W'(64'd1 << OUT_FRAC_BITS);
    localparam logic [31:0]      LN2_Q32   = 32'hB17217F8;

    localparam int NORM_CELLS = 6;
    localparam int LOG_CELLS  = 24;
    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS  = 32;

    localparam int Q_SHR = (UNIFORM_BITS >= 32) ? UNIFORM_BITS - 32 : 0;
    localparam int Q_SHL = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;
    localparam logic [IN_W-1:0] U_MASK =
        (UNIFORM_BITS >= IN_W) ? {IN_W{1'b1}} : IN_W'((64'd1 << UNIFORM_BITS) - 64'd1);

    // One word in flight; each stage uses the fields it needs and hands on the rest.
    typedef struct packed {
        logic             vld;
        logic [1:0]       neg;
        logic [1:0][31:0] mag;
        logic [62:0]      rad;
        logic [62:0]      nx;
        logic [5:0]       lz;
        logic [31:0]      mant;
        logic [23:0]      frac;
        logic [1:0][63:0] sx;
        logic [1:0][63:0] sr;
        logic [1:0][63:0] num;
        logic [1:0][31:0] rem;
        logic [1:0][31:0] quo;
    } item_t;

    // Bring a uniform to 32 fraction bits.
    function automatic logic [31:0] to_q32(input logic [IN_W-1:0] u);
        logic [IN_W-1:0] masked;
        masked = u & U_MASK;
        return 32'((masked >> Q_SHR) << Q_SHL);
    endfunction

endpackage

FILE: design/pgs_norm_cell.sv
// Normalizer cell: shift the radius left by a fixed amount when its top bits are clear.
module pgs_norm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [5:0]      shift,
    input  pgs_pkg::item_t  item_in,
    output pgs_pkg::item_t  item_out
);
    pgs_pkg::item_t item_next;
    pgs_pkg::item_t item_reg;
    logic           vld_reg;

    always_comb
    begin
        item_next = item_in;
        if ((item_in.nx >> (7'd63 - {1'b0, shift})) == 63'd0)
        begin
            item_next.nx = item_in.nx << shift;
            item_next.lz = item_in.lz + shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= item_in.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    always_comb
    begin
        item_out     = item_reg;
        item_out.vld = vld_reg;
    end
endmodule

FILE: design/pgs_log_cell.sv
// Log cell: one squaring step of the mantissa, one fraction bit of log2.
module pgs_log_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  pgs_pkg::item_t  item_in,
    output pgs_pkg::item_t  item_out
);
    pgs_pkg::item_t item_next;
    pgs_pkg::item_t item_reg;
    logic           vld_reg;
    logic [63:0]    sq;
    logic [32:0]    sh;

    always_comb
    begin
        item_next = item_in;
        sq        = item_in.mant * item_in.mant;
        sh        = sq[63:31];
        item_next.frac = {item_in.frac[22:0], sh[32]};
        item_next.mant = sh[32] ? sh[32:1] : sh[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= item_in.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    always_comb
    begin
        item_out     = item_reg;
        item_out.vld = vld_reg;
    end
endmodule

FILE: design/pgs_sqrt_cell.sv
// Square-root cell: one result bit of the integer root, for both lanes.
module pgs_sqrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [4:0]      step,
    input  pgs_pkg::item_t  item_in,
    output pgs_pkg::item_t  item_out
);
    pgs_pkg::item_t item_next;
    pgs_pkg::item_t item_reg;
    logic           vld_reg;
    logic [63:0]    bitv;
    logic [1:0][63:0] trial;

    always_comb
    begin
        item_next = item_in;
        bitv      = 64'd1 << (7'd62 - {1'b0, step, 1'b0});
        for (int l = 0; l < 2; l++)
        begin
            trial[l] = item_in.sr[l] + bitv;
            if (item_in.sx[l] >= trial[l])
            begin
                item_next.sx[l] = item_in.sx[l] - trial[l];
                item_next.sr[l] = (item_in.sr[l] >> 1) + bitv;
            end
            else
            begin
                item_next.sr[l] = item_in.sr[l] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= item_in.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    always_comb
    begin
        item_out     = item_reg;
        item_out.vld = vld_reg;
    end
endmodule

FILE: design/pgs_div_cell.sv
// Divider cell: one restoring quotient bit for both components.
module pgs_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [4:0]      step,
    input  pgs_pkg::item_t  item_in,
    output pgs_pkg::item_t  item_out
);
    pgs_pkg::item_t item_next;
    pgs_pkg::item_t item_reg;
    logic           vld_reg;
    logic [4:0]     idx;
    logic [32:0]    dvs;
    logic [1:0][31:0] low;
    logic [1:0][32:0] rem2;

    always_comb
    begin
        item_next = item_in;
        idx       = 5'd31 - step;
        dvs       = {1'b0, item_in.sr[1][31:0]};
        for (int l = 0; l < 2; l++)
        begin
            low[l]  = item_in.num[l][31:0];
            rem2[l] = {item_in.rem[l], low[l][idx]};
            if (rem2[l] >= dvs)
            begin
                item_next.rem[l]      = 32'(rem2[l] - dvs);
                item_next.quo[l][idx] = 1'b1;
            end
            else
            begin
                item_next.rem[l] = rem2[l][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= item_in.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    always_comb
    begin
        item_out     = item_reg;
        item_out.vld = vld_reg;
    end
endmodule

FILE: design/polar_gaussian_sampler.sv
// Top level of the polar-method Gaussian sampler pipeline.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word: a pair of uniforms
//   uniform_first/uniform_second in unsigned Q0.32. A pair whose radius
//   r = U1^2 + U2^2 is zero or above one is dropped and gives nothing.
//   Output channel (out_valid/out_ready) gives two words per kept pair:
//   U1*w*sd+mean, then U2*w*sd+mean with last_of_pair set, signed Q16.16,
//   saturated. The user must write mean_value and std_deviation through
//   cfg_we, cfg_index, cfg_data while the block is idle; it is not enforced.
// Timing:
//   The pipeline has 3 setup stages, 6 normalizer cells, 24 log cells (one
//   squaring multiply each), 32 root cells, 32 divider cells (one bit each)
//   and the scaling stages. A pair enters every cycle while in_ready is high;
//   each kept pair holds the output register until both results are taken,
//   so in_ready drops while the first result waits.
// Reset clears all valid bits and the output register's flags and loads
//   mean 0 and standard deviation 1.0. When the receiver stalls, the whole
//   pipeline holds in place and in_ready stays low; no word is lost.
module polar_gaussian_sampler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pgs_pkg::IN_W-1:0]        uniform_first,
    input  logic [pgs_pkg::IN_W-1:0]        uniform_second,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [pgs_pkg::OUT_W-1:0] normal_value,
    output logic                            last_of_pair,
    input  logic                            cfg_we,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pgs_pkg::CFG_W-1:0]       cfg_data
);
    // Configuration registers
    logic signed [31:0] mean_reg;
    logic [31:0]        std_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            std_reg  <= pgs_pkg::STD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pgs_pkg::REG_MEAN: mean_reg <= $signed(cfg_data);
                pgs_pkg::REG_STD:  std_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Global advance: the pipeline moves when the output register frees up
    logic obuf_full_reg;
    logic phase_reg;
    logic adv;

    assign adv      = !obuf_full_reg || (phase_reg && out_ready);
    assign in_ready = adv;

    // Stage 0: map uniforms to sign and magnitude of U = u - 2^31
    pgs_pkg::item_t   s0_next, s0_reg, s0_out;
    logic             s0_vld_reg;
    logic [1:0][31:0] uq;

    always_comb
    begin
        s0_next = '0;
        uq[0]   = pgs_pkg::to_q32(uniform_first);
        uq[1]   = pgs_pkg::to_q32(uniform_second);
        for (int l = 0; l < 2; l++)
        begin
            s0_next.neg[l] = ~uq[l][31];
            s0_next.mag[l] = uq[l][31] ? {1'b0, uq[l][30:0]} : 32'h8000_0000 - uq[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (adv)
            s0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s0_reg <= s0_next;
    end

    always_comb
    begin
        s0_out     = s0_reg;
        s0_out.vld = s0_vld_reg;
    end

    // Stage 1: square both components
    pgs_pkg::item_t s1_next, s1_reg, s1_out;
    logic           s1_vld_reg;

    always_comb
    begin
        s1_next = s0_out;
        for (int l = 0; l < 2; l++)
            s1_next.sx[l] = s0_out.mag[l] * s0_out.mag[l];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= s0_out.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s1_reg <= s1_next;
    end

    always_comb
    begin
        s1_out     = s1_reg;
        s1_out.vld = s1_vld_reg;
    end

    // Stage 2: radius and the reject test; a dropped pair becomes a bubble
    pgs_pkg::item_t s2_next, s2_reg, s2_out;
    logic           s2_vld_reg;
    logic [63:0]    rsum;
    logic           keep;

    always_comb
    begin
        s2_next    = s1_out;
        rsum       = s1_out.sx[0] + s1_out.sx[1];
        keep       = (rsum != 64'd0) && (rsum <= (64'd1 << 62));
        s2_next.rad = rsum[62:0];
        s2_next.nx  = rsum[62:0];
        s2_next.lz  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_out.vld && keep;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_reg <= s2_next;
    end

    always_comb
    begin
        s2_out     = s2_reg;
        s2_out.vld = s2_vld_reg;
    end

    // Normalizer cells: shift by 32, 16, 8, 4, 2, 1 and count leading zeros
    pgs_pkg::item_t norm_io [pgs_pkg::NORM_CELLS+1];
    assign norm_io[0] = s2_out;

    for (genvar j = 0; j < pgs_pkg::NORM_CELLS; j++)
    begin : g_norm
        pgs_norm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .shift    (6'(32 >> j)),
            .item_in  (norm_io[j]),
            .item_out (norm_io[j+1])
        );
    end

    // Log cells: the mantissa is the top 32 bits of the normalized radius
    pgs_pkg::item_t log_io [pgs_pkg::LOG_CELLS+1];

    always_comb
    begin
        log_io[0]      = norm_io[pgs_pkg::NORM_CELLS];
        log_io[0].mant = norm_io[pgs_pkg::NORM_CELLS].nx[62:31];
        log_io[0].frac = '0;
    end

    for (genvar j = 0; j < pgs_pkg::LOG_CELLS; j++)
    begin : g_log
        pgs_log_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .item_in  (log_io[j]),
            .item_out (log_io[j+1])
        );
    end

    // Stage 4: -log2 r times ln 2, doubled; radius scaled by 4^k for the root
    pgs_pkg::item_t s4_next, s4_reg, s4_out, s4_in;
    logic           s4_vld_reg;
    logic [29:0]    tlog;
    logic [61:0]    tprod;

    always_comb
    begin
        s4_in      = log_io[pgs_pkg::LOG_CELLS];
        s4_next    = s4_in;
        tlog       = {s4_in.lz, 24'd0} - {6'd0, s4_in.frac};
        tprod      = tlog * pgs_pkg::LN2_Q32;
        s4_next.sx[0] = {1'b0, tprod, 1'b0};
        s4_next.sx[1] = {1'b0, s4_in.rad} << {s4_in.lz[5:1], 1'b0};
        s4_next.sr    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (adv)
            s4_vld_reg <= s4_in.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s4_reg <= s4_next;
    end

    always_comb
    begin
        s4_out     = s4_reg;
        s4_out.vld = s4_vld_reg;
    end

    // Root cells: lane 0 gives sqrt(-2 ln r), lane 1 gives sqrt(r * 4^k)
    pgs_pkg::item_t sqrt_io [pgs_pkg::SQRT_CELLS+1];
    assign sqrt_io[0] = s4_out;

    for (genvar j = 0; j < pgs_pkg::SQRT_CELLS; j++)
    begin : g_sqrt
        pgs_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .step     (5'(j)),
            .item_in  (sqrt_io[j]),
            .item_out (sqrt_io[j+1])
        );
    end

    // Stage 5: dividends |U| << k << 31; the upper half is the first remainder
    pgs_pkg::item_t s5_next, s5_reg, s5_out, s5_in;
    logic           s5_vld_reg;
    logic [6:0]     dshift;

    always_comb
    begin
        s5_in   = sqrt_io[pgs_pkg::SQRT_CELLS];
        s5_next = s5_in;
        dshift  = {2'b0, s5_in.lz[5:1]} + 7'd31;
        for (int l = 0; l < 2; l++)
        begin
            s5_next.num[l] = {32'd0, s5_in.mag[l]} << dshift;
            s5_next.rem[l] = s5_next.num[l][63:32];
            s5_next.quo[l] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (adv)
            s5_vld_reg <= s5_in.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s5_reg <= s5_next;
    end

    always_comb
    begin
        s5_out     = s5_reg;
        s5_out.vld = s5_vld_reg;
    end

    // Divider cells: |U| / sqrt(r) with 31 fraction bits
    pgs_pkg::item_t div_io [pgs_pkg::DIV_CELLS+1];
    assign div_io[0] = s5_out;

    for (genvar j = 0; j < pgs_pkg::DIV_CELLS; j++)
    begin : g_div
        pgs_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .step     (5'(j)),
            .item_in  (div_io[j]),
            .item_out (div_io[j+1])
        );
    end

    // Stage 6: quotient times sqrt(-2 ln r)
    pgs_pkg::item_t   s6_in;
    logic             s6_vld_reg;
    logic [1:0]       s6_neg_reg;
    logic [1:0][63:0] s6_prod_reg;

    assign s6_in = div_io[pgs_pkg::DIV_CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else if (adv)
            s6_vld_reg <= s6_in.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_neg_reg <= s6_in.neg;
            for (int l = 0; l < 2; l++)
                s6_prod_reg[l] <= s6_in.quo[l] * s6_in.sr[0][31:0];
        end
    end

    // Stage 7: round to 24 fraction bits
    logic             s7_vld_reg;
    logic [1:0]       s7_neg_reg;
    logic [1:0][29:0] s7_n_reg;
    logic [1:0][63:0] s7_sum;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
            s7_sum[l] = s6_prod_reg[l] + (64'd1 << 34);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_vld_reg <= 1'b0;
        else if (adv)
            s7_vld_reg <= s6_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_neg_reg <= s6_neg_reg;
            for (int l = 0; l < 2; l++)
                s7_n_reg[l] <= 30'(s7_sum[l] >> 35);
        end
    end

    // Stage 8: scale by the standard deviation
    logic             s8_vld_reg;
    logic [1:0]       s8_neg_reg;
    logic [1:0][61:0] s8_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_vld_reg <= 1'b0;
        else if (adv)
            s8_vld_reg <= s7_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_neg_reg <= s7_neg_reg;
            for (int l = 0; l < 2; l++)
                s8_m_reg[l] <= s7_n_reg[l] * std_reg;
        end
    end

    // Stage 9: round the magnitude to the output fraction
    logic             s9_vld_reg;
    logic [1:0]       s9_neg_reg;
    logic [1:0][38:0] s9_mm_reg;
    logic [1:0][62:0] s9_sum;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
            s9_sum[l] = {1'b0, s8_m_reg[l]} + (63'd1 << 23);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_vld_reg <= 1'b0;
        else if (adv)
            s9_vld_reg <= s8_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_neg_reg <= s8_neg_reg;
            for (int l = 0; l < 2; l++)
                s9_mm_reg[l] <= 39'(s9_sum[l] >> 24);
        end
    end

    // Apply sign, add the mean, saturate into the output register
    logic signed [1:0][40:0] sval;
    logic [1:0][31:0]        sat;
    logic [1:0][31:0]        oval_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            sval[l] = (s9_neg_reg[l] ? -$signed({2'b0, s9_mm_reg[l]})
                                     :  $signed({2'b0, s9_mm_reg[l]}))
                      + 41'($signed(mean_reg));
            if ($signed(sval[l]) > $signed(41'sh0_7FFF_FFFF))
                sat[l] = 32'h7FFF_FFFF;
            else if ($signed(sval[l]) < -$signed(41'sh0_8000_0000))
                sat[l] = 32'h8000_0000;
            else
                sat[l] = sval[l][31:0];
        end
    end

    // Output register: hold both results, hand them out first then last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_full_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (adv)
        begin
            obuf_full_reg <= s9_vld_reg;
            phase_reg     <= 1'b0;
        end
        else if (out_ready)
        begin
            phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            oval_reg <= sat;
    end

    assign out_valid    = obuf_full_reg;
    assign last_of_pair = phase_reg;
    assign normal_value = $signed(phase_reg ? oval_reg[1] : oval_reg[0]);

    // The first result taken is always followed by its partner
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_pair |=> out_valid && last_of_pair)
        else $error("first result not followed by the last of its pair");

    // Input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output register");

    // A pending first result always blocks the pipeline
    a_first_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_pair |-> !in_ready)
        else $error("pipeline advanced over a pending first result");

endmodule
